### design/dce_pkg.sv
// Shared types, codes and protocol constants for the dispenser command exchange.
package dce_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_RX_BYTE = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // Result codes.
  localparam logic [2:0] RES_OK         = 3'd0;
  localparam logic [2:0] RES_TIMEOUT    = 3'd1;
  localparam logic [2:0] RES_NAK        = 3'd2;
  localparam logic [2:0] RES_BAD_ACK    = 3'd3;
  localparam logic [2:0] RES_FRAME_NONE = 3'd4;
  localparam logic [2:0] RES_FRAME_ERR  = 3'd5;

  // Line protocol bytes.
  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_ETX   = 8'h03;
  localparam logic [7:0] BYTE_ENQ   = 8'h05;
  localparam logic [7:0] BYTE_ACK   = 8'h06;
  localparam logic [7:0] BYTE_NAK   = 8'h15;
  localparam logic [7:0] BYTE_S     = 8'h53;
  localparam logic [7:0] BYTE_F     = 8'h46;
  localparam logic [7:0] BYTE_DIGIT = 8'h30;

  // Attempt frame position of the last transmitted byte.
  localparam logic [2:0] FRAME_LAST_IDX = 3'd4;

  localparam logic [7:0] MAX_RETRY_RESET = 8'd3;

  // One input request.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] cmd_code;
    logic        want_status;
    logic [7:0]  rx_byte;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        flush;
    logic        done_res;
    logic [2:0]  result_code;
    logic [23:0] status_value;
    logic        last;
  } out_item_t;

  // Descriptor of the results caused by one input: either a five-byte
  // attempt frame or one single result.
  typedef struct packed {
    logic        attempt;
    logic [15:0] code;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        done_res;
    logic [2:0]  result_code;
    logic [23:0] status_value;
  } burst_t;

endpackage

### design/dce_ctrl.sv
// Exchange controller: retry register, exchange state and result decode.
module dce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              accept,
  input  dce_pkg::in_item_t item,
  output logic              push,
  output dce_pkg::burst_t   burst
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_REPLY = 2'd1;
  localparam logic [1:0] PH_FRAME = 2'd2;

  logic [7:0]  max_retry_r, max_retry_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  attempts_r, attempts_nxt;
  logic [15:0] code_r, code_nxt;
  logic        status_mode_r, status_mode_nxt;
  logic [2:0]  fcount_r, fcount_nxt;
  logic [7:0]  fxor_r, fxor_nxt;
  logic        fbad_r, fbad_nxt;
  logic [23:0] digits_r, digits_nxt;

  logic        fail_req;
  logic [2:0]  fail_code;
  logic        frame_bad_now;
  logic [7:0]  digit;

  // Retry limit register; a zero write is ignored.
  assign max_retry_nxt = (cfg_wr_en && cfg_wr_data != 8'd0) ? cfg_wr_data : max_retry_r;

  assign digit = item.rx_byte - dce_pkg::BYTE_DIGIT;

  // Next state and result descriptor for the accepted request.
  always_comb begin
    phase_nxt       = phase_r;
    attempts_nxt    = attempts_r;
    code_nxt        = code_r;
    status_mode_nxt = status_mode_r;
    fcount_nxt      = fcount_r;
    fxor_nxt        = fxor_r;
    fbad_nxt        = fbad_r;
    digits_nxt      = digits_r;
    fail_req        = 1'b0;
    fail_code       = dce_pkg::RES_OK;
    frame_bad_now   = fbad_r;
    push            = 1'b0;
    burst           = '0;
    burst.code      = code_r;

    if (accept) begin
      case (item.command)
        dce_pkg::CMD_START: begin
          code_nxt        = item.cmd_code;
          status_mode_nxt = item.want_status;
          attempts_nxt    = 8'd1;
          fcount_nxt      = '0;
          fxor_nxt        = '0;
          fbad_nxt        = 1'b0;
          digits_nxt      = '0;
          phase_nxt       = PH_REPLY;
          push            = 1'b1;
          burst.attempt   = 1'b1;
          burst.code      = item.cmd_code;
        end
        dce_pkg::CMD_RX_BYTE: begin
          if (phase_r == PH_REPLY) begin
            if (item.rx_byte == dce_pkg::BYTE_ACK) begin
              push           = 1'b1;
              burst.tx_valid = 1'b1;
              burst.tx_byte  = dce_pkg::BYTE_ENQ;
              if (status_mode_r) begin
                phase_nxt  = PH_FRAME;
                fcount_nxt = '0;
                fxor_nxt   = '0;
                fbad_nxt   = 1'b0;
                digits_nxt = '0;
              end else begin
                phase_nxt      = PH_IDLE;
                burst.done_res = 1'b1;
              end
            end else if (item.rx_byte == dce_pkg::BYTE_NAK) begin
              if (status_mode_r) begin
                fail_req  = 1'b1;
                fail_code = dce_pkg::RES_NAK;
              end else begin
                phase_nxt         = PH_IDLE;
                push              = 1'b1;
                burst.done_res    = 1'b1;
                burst.result_code = dce_pkg::RES_NAK;
              end
            end else begin
              fail_req  = 1'b1;
              fail_code = dce_pkg::RES_BAD_ACK;
            end
          end else if (phase_r == PH_FRAME) begin
            // Header, digits and trailer checks by frame position.
            case (fcount_r)
              3'd0: frame_bad_now = fbad_r | (item.rx_byte != dce_pkg::BYTE_STX);
              3'd1: frame_bad_now = fbad_r | (item.rx_byte != dce_pkg::BYTE_S);
              3'd2: frame_bad_now = fbad_r | (item.rx_byte != dce_pkg::BYTE_F);
              3'd6: frame_bad_now = fbad_r | (item.rx_byte != dce_pkg::BYTE_ETX);
              3'd7: frame_bad_now = fbad_r | (item.rx_byte != fxor_r);
              default: frame_bad_now = fbad_r;
            endcase
            if (fcount_r inside {3'd3, 3'd4, 3'd5}) begin
              digits_nxt = {digits_r[15:0], digit};
            end
            fbad_nxt = frame_bad_now;
            if (fcount_r == 3'd7) begin
              fcount_nxt = '0;
              phase_nxt  = PH_IDLE;
              if (!frame_bad_now) begin
                push               = 1'b1;
                burst.done_res     = 1'b1;
                burst.status_value = digits_r;
              end else begin
                fail_req  = 1'b1;
                fail_code = dce_pkg::RES_FRAME_ERR;
              end
            end else begin
              fxor_nxt   = fxor_r ^ item.rx_byte;
              fcount_nxt = fcount_r + 3'd1;
            end
          end
        end
        dce_pkg::CMD_TIMEOUT: begin
          if (phase_r == PH_REPLY) begin
            fail_req  = 1'b1;
            fail_code = dce_pkg::RES_TIMEOUT;
          end else if (phase_r == PH_FRAME) begin
            fail_req  = 1'b1;
            fail_code = (fcount_r == 3'd0) ? dce_pkg::RES_FRAME_NONE
                                           : dce_pkg::RES_FRAME_ERR;
          end
        end
        default: begin
        end
      endcase

      // A failure retries while attempts remain, otherwise ends the exchange.
      if (fail_req) begin
        push = 1'b1;
        if (attempts_r < max_retry_r) begin
          attempts_nxt  = attempts_r + 8'd1;
          phase_nxt     = PH_REPLY;
          burst.attempt = 1'b1;
        end else begin
          phase_nxt         = PH_IDLE;
          burst.done_res    = 1'b1;
          burst.result_code = fail_code;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retry_r   <= dce_pkg::MAX_RETRY_RESET;
      phase_r       <= PH_IDLE;
      attempts_r    <= '0;
      code_r        <= '0;
      status_mode_r <= 1'b0;
      fcount_r      <= '0;
      fxor_r        <= '0;
      fbad_r        <= 1'b0;
      digits_r      <= '0;
    end else begin
      max_retry_r   <= max_retry_nxt;
      phase_r       <= phase_nxt;
      attempts_r    <= attempts_nxt;
      code_r        <= code_nxt;
      status_mode_r <= status_mode_nxt;
      fcount_r      <= fcount_nxt;
      fxor_r        <= fxor_nxt;
      fbad_r        <= fbad_nxt;
      digits_r      <= digits_nxt;
    end
  end

  // An exchange in progress has always used at least one attempt.
  a_attempts_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> attempts_r != 8'd0)
    else $error("exchange active with no attempt counted");

  // The retry limit is never zero.
  a_retry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    max_retry_r != 8'd0)
    else $error("retry limit became zero");

  // Frame collection only happens in status mode.
  a_frame_status: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FRAME |-> status_mode_r)
    else $error("frame collection outside status mode");

  // A start always leaves the block waiting for a reply.
  a_start_reply: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.command == dce_pkg::CMD_START |=> phase_r == PH_REPLY)
    else $error("start did not enter reply wait");

endmodule

### design/dce_emit.sv
// Result register and sequencer, one burst request per unstalled cycle.
module dce_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dce_pkg::burst_t    burst,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output dce_pkg::out_item_t out_item
);

  dce_pkg::burst_t burst_r, burst_nxt;
  logic            busy_r, busy_nxt;
  logic [2:0]      idx_r, idx_nxt;
  logic            pop;
  logic            is_last;
  logic [7:0]      hi_byte;
  logic [7:0]      lo_byte;

  assign hi_byte = burst_r.code[15:8];
  assign lo_byte = burst_r.code[7:0];
  assign is_last = !burst_r.attempt || idx_r == dce_pkg::FRAME_LAST_IDX;
  assign pop     = busy_r && !out_stall;
  assign free    = !busy_r || (pop && is_last);

  // Build the current result from the held descriptor.
  always_comb begin
    out_item = '0;
    out_item.last = is_last;
    if (burst_r.attempt) begin
      out_item.tx_valid = 1'b1;
      out_item.flush    = (idx_r == 3'd0);
      case (idx_r)
        3'd0:    out_item.tx_byte = dce_pkg::BYTE_STX;
        3'd1:    out_item.tx_byte = hi_byte;
        3'd2:    out_item.tx_byte = lo_byte;
        3'd3:    out_item.tx_byte = dce_pkg::BYTE_ETX;
        default: out_item.tx_byte = dce_pkg::BYTE_STX ^ hi_byte ^ lo_byte ^ dce_pkg::BYTE_ETX;
      endcase
    end else begin
      out_item.tx_valid     = burst_r.tx_valid;
      out_item.tx_byte      = burst_r.tx_byte;
      out_item.done_res     = burst_r.done_res;
      out_item.result_code  = burst_r.result_code;
      out_item.status_value = burst_r.status_value;
    end
  end

  assign out_valid = busy_r;

  // Burst load and advance.
  always_comb begin
    burst_nxt = burst_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    if (push) begin
      burst_nxt = burst;
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
    end else if (pop) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    burst_r <= burst_nxt;
  end

  // A new burst is loaded only when the previous one is gone or finishing.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> free)
    else $error("burst overwritten before it was sent");

  // The position never runs past the end of an attempt frame.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= dce_pkg::FRAME_LAST_IDX)
    else $error("burst position out of range");

  // Single results never advance the position.
  a_single_idx: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !burst_r.attempt |-> idx_r == 3'd0)
    else $error("single result with nonzero position");

endmodule

### design/dispenser_command_exchange_core.sv
// Top level of the dispenser command exchange host controller.
// Each accepted request is decoded combinationally against the exchange state and
// turns into zero, one or five results: a start, or a reply byte or timeout that
// leads to a retry, sends a five-byte attempt frame (STX, two command bytes, ETX,
// XOR check, the first byte flagged flush); any other request gives at most one
// result. The result sequencer sends one result per cycle while out_stall is low,
// so after a request with one result or none the next may follow in the next
// cycle unless the result side stalls, while an attempt frame keeps the input
// stalled until its fifth byte leaves. The retry limit register is written
// through cfg_wr_en and cfg_wr_data; a zero write is ignored.
module dispenser_command_exchange_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  dce_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dce_pkg::out_item_t out_item
);

  logic            accept;
  logic            push;
  logic            free;
  dce_pkg::burst_t burst;

  // A request is taken once the result register can hold its results.
  assign in_stall = !free;
  assign accept   = in_valid && free;

  dce_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .item        (in_item),
    .push        (push),
    .burst       (burst)
  );

  dce_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .burst     (burst),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### test/testbench.sv
// Self-checking testbench for the dispenser command exchange core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Command value that the block has no meaning for.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PRINT_CAP = 100;
  localparam int ITEMS_PER_SETTING = 13;

  typedef enum logic [1:0] {XCH_IDLE, XCH_REPLY, XCH_FRAME} xch_phase_e;

  typedef struct {
    dce_pkg::in_item_t  req;
    bit                 typed;
    dce_pkg::out_item_t result;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic      in_valid;
  logic      in_stall;
  dce_pkg::in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  dce_pkg::out_item_t out_item;

  // Exchange state as the block should hold it.
  logic [7:0]  retry_limit = dce_pkg::MAX_RETRY_RESET;
  xch_phase_e  xch_phase = XCH_IDLE;
  logic [7:0]  tries = '0;
  logic [15:0] code_word = '0;
  logic        status_wanted = 1'b0;
  logic [3:0]  frame_pos = '0;
  logic [7:0]  frame_sum = '0;
  logic        frame_broken = 1'b0;
  logic [23:0] digits = '0;

  dce_pkg::out_item_t step_results[$];
  dce_pkg::out_item_t awaited_items[$];
  directed_row_t      directed_rows[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;
  int            stall_left = 0;

  dispenser_command_exchange_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic report(input string what);
    if (error_count < PRINT_CAP) $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  // Predictor building blocks, each adding results to step_results.
  task automatic push_result(input logic txv, input logic [7:0] txb, input logic fl,
                             input logic dn, input logic [2:0] code,
                             input logic [23:0] st);
    dce_pkg::out_item_t r;
    r.tx_valid = txv;
    r.tx_byte = txb;
    r.flush = fl;
    r.done_res = dn;
    r.result_code = code;
    r.status_value = st;
    r.last = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic send_attempt_frame();
    logic [7:0] hi;
    logic [7:0] lo;
    hi = code_word[15:8];
    lo = code_word[7:0];
    if (tries != 8'hFF) tries++;
    push_result(1'b1, dce_pkg::BYTE_STX, 1'b1, 1'b0, dce_pkg::RES_OK, '0);
    push_result(1'b1, hi, 1'b0, 1'b0, dce_pkg::RES_OK, '0);
    push_result(1'b1, lo, 1'b0, 1'b0, dce_pkg::RES_OK, '0);
    push_result(1'b1, dce_pkg::BYTE_ETX, 1'b0, 1'b0, dce_pkg::RES_OK, '0);
    push_result(1'b1, dce_pkg::BYTE_STX ^ hi ^ lo ^ dce_pkg::BYTE_ETX, 1'b0, 1'b0,
                dce_pkg::RES_OK, '0);
    xch_phase = XCH_REPLY;
  endtask

  task automatic close_exchange(input logic [2:0] code, input logic [23:0] st);
    xch_phase = XCH_IDLE;
    push_result(1'b0, 8'h00, 1'b0, 1'b1, code, st);
  endtask

  task automatic retry_or_close(input logic [2:0] code);
    if (tries < retry_limit) send_attempt_frame();
    else close_exchange(code, '0);
  endtask

  task automatic take_reply_byte(input logic [7:0] b);
    if (b == dce_pkg::BYTE_ACK) begin
      if (!status_wanted) begin
        xch_phase = XCH_IDLE;
        push_result(1'b1, dce_pkg::BYTE_ENQ, 1'b0, 1'b1, dce_pkg::RES_OK, '0);
      end else begin
        xch_phase = XCH_FRAME;
        frame_pos = '0;
        frame_sum = '0;
        frame_broken = 1'b0;
        digits = '0;
        push_result(1'b1, dce_pkg::BYTE_ENQ, 1'b0, 1'b0, dce_pkg::RES_OK, '0);
      end
    end else if (b == dce_pkg::BYTE_NAK) begin
      if (!status_wanted) close_exchange(dce_pkg::RES_NAK, '0);
      else retry_or_close(dce_pkg::RES_NAK);
    end else begin
      retry_or_close(dce_pkg::RES_BAD_ACK);
    end
  endtask

  task automatic take_frame_byte(input logic [7:0] b);
    logic [3:0] pos;
    logic [7:0] digit;
    pos = frame_pos;
    digit = b - dce_pkg::BYTE_DIGIT;
    if (pos < 4'd7) frame_sum ^= b;
    case (pos)
      4'd0: if (b != dce_pkg::BYTE_STX) frame_broken = 1'b1;
      4'd1: if (b != dce_pkg::BYTE_S) frame_broken = 1'b1;
      4'd2: if (b != dce_pkg::BYTE_F) frame_broken = 1'b1;
      4'd3, 4'd4, 4'd5: digits = {digits[15:0], digit};
      4'd6: if (b != dce_pkg::BYTE_ETX) frame_broken = 1'b1;
      default: ;
    endcase
    if (pos >= 4'd7) begin
      if (b != frame_sum) frame_broken = 1'b1;
      frame_pos = '0;
      xch_phase = XCH_IDLE;
      if (!frame_broken) close_exchange(dce_pkg::RES_OK, digits);
      else retry_or_close(dce_pkg::RES_FRAME_ERR);
    end else begin
      frame_pos = pos + 4'd1;
    end
  endtask

  // Works out every result that one accepted request causes.
  task automatic predict_exchange(input dce_pkg::in_item_t req);
    dce_pkg::out_item_t tail;
    step_results.delete();
    case (req.command)
      dce_pkg::CMD_START: begin
        code_word = req.cmd_code;
        status_wanted = req.want_status;
        tries = '0;
        frame_pos = '0;
        frame_sum = '0;
        frame_broken = 1'b0;
        digits = '0;
        send_attempt_frame();
      end
      dce_pkg::CMD_RX_BYTE: begin
        if (xch_phase == XCH_REPLY) take_reply_byte(req.rx_byte);
        else if (xch_phase == XCH_FRAME) take_frame_byte(req.rx_byte);
      end
      dce_pkg::CMD_TIMEOUT: begin
        if (xch_phase == XCH_REPLY) retry_or_close(dce_pkg::RES_TIMEOUT);
        else if (xch_phase == XCH_FRAME)
          retry_or_close(frame_pos == 4'd0 ? dce_pkg::RES_FRAME_NONE
                                           : dce_pkg::RES_FRAME_ERR);
      end
      default: ;
    endcase
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
  endtask

  // Closing result of an exchange, as typed into the directed table.
  function automatic dce_pkg::out_item_t final_item(input logic txv,
                                                    input logic [7:0] txb,
                                                    input logic [2:0] code,
                                                    input logic [23:0] st);
    dce_pkg::out_item_t r;
    r.tx_valid = txv;
    r.tx_byte = txb;
    r.flush = 1'b0;
    r.done_res = 1'b1;
    r.result_code = code;
    r.status_value = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [15:0] code,
                         input logic ws, input logic [7:0] b,
                         input bit typed = 1'b0,
                         input dce_pkg::out_item_t result = '0);
    directed_row_t row;
    row.req.command = cmd;
    row.req.cmd_code = code;
    row.req.want_status = ws;
    row.req.rx_byte = b;
    row.typed = typed;
    row.result = result;
    directed_rows.push_back(row);
  endtask

  // Drives one request after a random gap and waits until it is taken.
  task automatic send_request(input dce_pkg::in_item_t req, input bit typed,
                              input dce_pkg::out_item_t result);
    int gap;
    if ($urandom_range(9) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(14);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_item <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_exchange(req);
    if (typed) awaited_items.push_back(result);
    else foreach (step_results[i]) awaited_items.push_back(step_results[i]);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_items.size() != 0) @(posedge clk);
  endtask

  // Retry limit is changed only once the block has gone quiet.
  task automatic write_retry_limit(input logic [7:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (value != 8'd0) retry_limit = value;
  endtask

  // Picks a request that mostly follows a well-formed exchange.
  task automatic pick_request(output dce_pkg::in_item_t req);
    int roll;
    roll = $urandom_range(99);
    req.command = dce_pkg::CMD_RX_BYTE;
    req.cmd_code = 16'($urandom);
    req.want_status = ($urandom_range(9) < 6);
    req.rx_byte = 8'($urandom);
    case (xch_phase)
      XCH_IDLE: begin
        if (roll < 80) req.command = dce_pkg::CMD_START;
        else if (roll < 88) req.command = dce_pkg::CMD_RX_BYTE;
        else if (roll < 95) req.command = dce_pkg::CMD_TIMEOUT;
        else req.command = CMD_UNUSED;
      end
      XCH_REPLY: begin
        if (roll < 45) req.rx_byte = dce_pkg::BYTE_ACK;
        else if (roll < 60) req.rx_byte = dce_pkg::BYTE_NAK;
        else if (roll < 75) req.command = dce_pkg::CMD_TIMEOUT;
        else if (roll < 88) req.command = dce_pkg::CMD_RX_BYTE;
        else if (roll < 94) req.command = dce_pkg::CMD_START;
        else req.command = CMD_UNUSED;
      end
      default: begin
        if (roll < 80) begin
          case (frame_pos)
            4'd0: req.rx_byte = dce_pkg::BYTE_STX;
            4'd1: req.rx_byte = dce_pkg::BYTE_S;
            4'd2: req.rx_byte = dce_pkg::BYTE_F;
            4'd3, 4'd4, 4'd5:
              if ($urandom_range(9) != 0)
                req.rx_byte = dce_pkg::BYTE_DIGIT + 8'($urandom_range(9));
            4'd6: req.rx_byte = dce_pkg::BYTE_ETX;
            default: req.rx_byte = frame_sum;
          endcase
        end else if (roll < 88) begin
          req.command = dce_pkg::CMD_RX_BYTE;
        end else if (roll < 95) begin
          req.command = dce_pkg::CMD_TIMEOUT;
        end else begin
          req.command = dce_pkg::CMD_START;
        end
      end
    endcase
  endtask

  // Compares one taken result with the oldest awaited one.
  task automatic check_result(input dce_pkg::out_item_t got);
    dce_pkg::out_item_t want;
    if (awaited_items.size() == 0) begin
      report($sformatf("result %h arrived with nothing awaited", got));
    end else begin
      want = awaited_items.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report($sformatf("tx_valid got %0d want %0d", got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte got %h want %h", got.tx_byte, want.tx_byte));
      if (got.flush !== want.flush)
        report($sformatf("flush got %0d want %0d", got.flush, want.flush));
      if (got.done_res !== want.done_res)
        report($sformatf("done_res got %0d want %0d", got.done_res, want.done_res));
      if (got.result_code !== want.result_code)
        report($sformatf("result_code got %0d want %0d", got.result_code,
                         want.result_code));
      if (got.status_value !== want.status_value)
        report($sformatf("status_value got %h want %h", got.status_value,
                         want.status_value));
      if (got.last !== want.last)
        report($sformatf("last got %0d want %0d", got.last, want.last));
    end
  endtask

  // Result side: sample at the rising edge, stall at random from the falling edge.
  initial begin
    out_stall = 1'b0;
    stall_left = $urandom_range(14);
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_result(out_item);
        if ($urandom_range(9) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(14);
      end
      @(negedge clk);
      out_stall <= (stall_left != 0);
      if (out_valid && stall_left != 0) stall_left--;
    end
  end

  // Request side: reset, directed table, then random exchanges per retry limit.
  initial begin
    dce_pkg::in_item_t req;
    int         counted;
    logic [7:0] settings[6];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Noise while idle and an unused command value.
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, dce_pkg::BYTE_ACK);
    add_row(dce_pkg::CMD_TIMEOUT, 16'hFFFF, 1'b1, 8'hFF);
    add_row(CMD_UNUSED, 16'hFFFF, 1'b1, 8'hFF);
    // Plain exchanges ended by an acknowledge and by a refusal.
    add_row(dce_pkg::CMD_START, 16'hFFFF, 1'b0, 8'h00);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, dce_pkg::BYTE_ACK, 1'b1,
            final_item(1'b1, dce_pkg::BYTE_ENQ, dce_pkg::RES_OK, 24'h0));
    add_row(dce_pkg::CMD_START, 16'h0000, 1'b0, 8'hFF);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, dce_pkg::BYTE_NAK, 1'b1,
            final_item(1'b0, 8'h00, dce_pkg::RES_NAK, 24'h0));
    // A bad reply byte and two timeouts use up the three attempts after reset.
    add_row(dce_pkg::CMD_START, 16'h1234, 1'b0, 8'h00);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, 8'hFF);
    add_row(dce_pkg::CMD_TIMEOUT, 16'h0000, 1'b0, 8'h00);
    add_row(dce_pkg::CMD_TIMEOUT, 16'h0000, 1'b0, 8'h00, 1'b1,
            final_item(1'b0, 8'h00, dce_pkg::RES_TIMEOUT, 24'h0));
    // Status exchange with a clean frame carrying the digits 9, 0 and 5.
    add_row(dce_pkg::CMD_START, 16'h5354, 1'b1, 8'h00);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, dce_pkg::BYTE_ACK);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, dce_pkg::BYTE_STX);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, dce_pkg::BYTE_S);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, dce_pkg::BYTE_F);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, 8'h39);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, 8'h30);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, 8'h35);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, dce_pkg::BYTE_ETX);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, 8'h28, 1'b1,
            final_item(1'b0, 8'h00, dce_pkg::RES_OK, 24'h090005));
    // A start while busy, then a timeout before any frame byte.
    add_row(dce_pkg::CMD_START, 16'h4350, 1'b1, 8'h00);
    add_row(dce_pkg::CMD_START, 16'h5246, 1'b1, 8'h00);
    add_row(dce_pkg::CMD_RX_BYTE, 16'h0000, 1'b0, dce_pkg::BYTE_ACK);
    add_row(dce_pkg::CMD_TIMEOUT, 16'h0000, 1'b0, 8'h00);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed,
                   directed_rows[i].result);

    // A zero write must leave the previous limit in place.
    settings[0] = 8'd1;
    settings[1] = 8'd0;
    settings[2] = 8'd255;
    settings[3] = 8'd2;
    settings[4] = 8'($urandom_range(255, 1));
    settings[5] = 8'd4;
    foreach (settings[s]) begin
      write_retry_limit(settings[s]);
      counted = 0;
      while (counted < ITEMS_PER_SETTING) begin
        if ($urandom_range(14) == 0) hold_until_drained();
        pick_request(req);
        send_request(req, 1'b0, '0);
        counted++;
      end
    end

    // Drain and let any stray result show up.
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_items.size() != 0)
      report($sformatf("%0d results never arrived", awaited_items.size()));
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/dce_pkg.sv
design/dce_ctrl.sv
design/dce_emit.sv
design/dispenser_command_exchange_core.sv
test/testbench.sv
